// ----- hw/rtl/wcp_pkg.sv -----
// package: types, constants and helpers for the wall clip and project pipeline
`default_nettype none
package wcp_pkg;

  localparam int ScreenWidth  = 640;
  localparam int ScreenHeight = 480;
  localparam logic signed [31:0] HalfWidth  = 32'(ScreenWidth / 2);
  localparam logic signed [31:0] HalfHeight = 32'(ScreenHeight / 2);
  localparam logic signed [33:0] CoordLim   = 34'sd1073741824;

  localparam logic [2:0] RegViewerX    = 3'd0;
  localparam logic [2:0] RegViewerY    = 3'd1;
  localparam logic [2:0] RegCosHeading = 3'd2;
  localparam logic [2:0] RegSinHeading = 3'd3;
  localparam logic [2:0] RegEyeHeight  = 3'd4;
  localparam logic [2:0] RegConeSlope  = 3'd5;
  localparam logic [2:0] RegFocal      = 3'd6;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] floor_level;
    logic signed [31:0] ceiling_level;
  } in_word_t;

  typedef struct packed {
    logic               visible;
    logic               facing;
    logic signed [15:0] left_column;
    logic signed [15:0] right_column;
    logic signed [15:0] top_left;
    logic signed [15:0] bottom_left;
    logic signed [15:0] top_right;
    logic signed [15:0] bottom_right;
    logic signed [31:0] depth_left;
    logic signed [31:0] depth_right;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] viewer_x;
    logic signed [31:0] viewer_y;
    logic signed [31:0] cos_heading;
    logic signed [31:0] sin_heading;
    logic signed [31:0] eye_height;
    logic        [30:0] cone_slope;
    logic        [11:0] focal_length;
  } cfg_t;

  // viewer-frame segment, each coordinate within +-2^30
  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
  } seg_t;

  function automatic logic signed [31:0] sat_coord(input logic signed [95:0] v);
    logic signed [31:0] r;
    if (v > 96'(CoordLim)) r = 32'sd1073741824;
    else if (v < -96'(CoordLim)) r = -32'sd1073741824;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7fff;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/wcp_divider.sv -----
// pipelined signed restoring divider, one quotient bit per stage, truncating
`default_nettype none
module wcp_divider
  import wcp_pkg::*;
#(
  parameter int NumWidth = 64,
  parameter int DenWidth = 64,
  parameter int TagWidth = 1
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        en,
  input  wire                        in_valid,
  input  wire signed [NumWidth-1:0]  num,
  input  wire signed [DenWidth-1:0]  den,
  input  wire        [TagWidth-1:0]  tag_in,
  output logic                       out_valid,
  output logic       [NumWidth-1:0]  quot_mag,
  output logic                       quot_neg,
  output logic       [TagWidth-1:0]  tag_out
);

  localparam int Steps = NumWidth;

  logic [Steps:0]               vld;
  logic [NumWidth-1:0]          rem  [Steps+1];
  logic [NumWidth-1:0]          quo  [Steps+1];
  logic [DenWidth-1:0]          dmag [Steps+1];
  logic [Steps:0]               neg;
  logic [TagWidth-1:0]          tag  [Steps+1];

  always_comb begin
    vld[0]  = in_valid;
    rem[0]  = '0;
    quo[0]  = num[NumWidth-1] ? NumWidth'(-num) : num;
    dmag[0] = den[DenWidth-1] ? DenWidth'(-den) : den;
    neg[0]  = num[NumWidth-1] ^ den[DenWidth-1];
    tag[0]  = tag_in;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [NumWidth:0] trial;
    logic [NumWidth:0] rem_sh;
    always_comb begin
      rem_sh = {rem[i], quo[i][NumWidth-1]};
      trial  = rem_sh - (NumWidth+1)'(dmag[i]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        if (!trial[NumWidth]) begin
          rem[i+1] <= trial[NumWidth-1:0];
          quo[i+1] <= {quo[i][NumWidth-2:0], 1'b1};
        end else begin
          rem[i+1] <= rem_sh[NumWidth-1:0];
          quo[i+1] <= {quo[i][NumWidth-2:0], 1'b0};
        end
        dmag[i+1] <= dmag[i];
        neg[i+1]  <= neg[i];
        tag[i+1]  <= tag[i];
      end
    end
  end

  assign out_valid = vld[Steps];
  assign quot_mag  = quo[Steps];
  assign quot_neg  = neg[Steps];
  assign tag_out   = tag[Steps];

endmodule
`default_nettype wire

// ----- hw/rtl/wcp_delay.sv -----
// pipelined delay line for side data
`default_nettype none
module wcp_delay
  import wcp_pkg::*;
#(
  parameter int Width = 1,
  parameter int Depth = 1
) (
  input  wire              clk,
  input  wire              en,
  input  wire  [Width-1:0] d,
  output logic [Width-1:0] q
);

  logic [Width-1:0] taps [Depth+1];

  assign taps[0] = d;
  for (genvar i = 0; i < Depth; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) taps[i+1] <= taps[i];
    end
  end
  assign q = taps[Depth];

endmodule
`default_nettype wire

// ----- hw/rtl/wcp_rotate.sv -----
// translate and rotate both endpoints into the viewer frame, three stages
`default_nettype none
module wcp_rotate
  import wcp_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         en,
  input  wire         in_valid,
  input  in_word_t    in_word,
  input  cfg_t        cfg,
  output logic        out_valid,
  output seg_t        seg
);

  logic [2:0]        vld;
  logic signed [32:0] dx1, dy1, dx2, dy2;
  logic signed [65:0] m [8];
  logic signed [66:0] s [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
    if (en) begin
      dx1 <= 33'(in_word.start_x) - 33'(cfg.viewer_x);
      dy1 <= 33'(in_word.start_y) - 33'(cfg.viewer_y);
      dx2 <= 33'(in_word.end_x) - 33'(cfg.viewer_x);
      dy2 <= 33'(in_word.end_y) - 33'(cfg.viewer_y);
      m[0] <= 66'(dx1) * 66'(cfg.cos_heading);
      m[1] <= 66'(dy1) * 66'(cfg.sin_heading);
      m[2] <= 66'(dy1) * 66'(cfg.cos_heading);
      m[3] <= 66'(dx1) * 66'(cfg.sin_heading);
      m[4] <= 66'(dx2) * 66'(cfg.cos_heading);
      m[5] <= 66'(dy2) * 66'(cfg.sin_heading);
      m[6] <= 66'(dy2) * 66'(cfg.cos_heading);
      m[7] <= 66'(dx2) * 66'(cfg.sin_heading);
      s[0] <= 67'(m[0]) + 67'(m[1]);
      s[1] <= 67'(m[2]) - 67'(m[3]);
      s[2] <= 67'(m[4]) + 67'(m[5]);
      s[3] <= 67'(m[6]) - 67'(m[7]);
    end
  end

  assign out_valid = vld[2];
  assign seg.x1 = sat_coord(96'(s[0] >>> 30));
  assign seg.y1 = sat_coord(96'(s[1] >>> 30));
  assign seg.x2 = sat_coord(96'(s[2] >>> 30));
  assign seg.y2 = sat_coord(96'(s[3] >>> 30));

endmodule
`default_nettype wire

// ----- hw/rtl/wcp_clip.sv -----
// clip a segment against one view-cone line, pipelined divide for the crossing
`default_nettype none
module wcp_clip
  import wcp_pkg::*;
#(
  parameter bit Positive = 1'b0
) (
  input  wire   clk,
  input  wire   rst,
  input  wire   en,
  input  wire   in_valid,
  input  wire   in_rej,
  input  seg_t  seg_in,
  input  cfg_t  cfg,
  output logic  out_valid,
  output logic  out_rej,
  output seg_t  seg_out
);

  localparam int NumW = 80;
  localparam int TagW = 2 + $bits(seg_t);

  // stage a: products
  logic               va, rej_a;
  seg_t               sa;
  logic signed [63:0] c_a1, c_a2, d_kx;
  logic signed [63:0] o1l, o2l;
  logic signed [32:0] ksl;
  logic signed [32:0] ks;

  assign ks = Positive ? 33'(signed'({1'b0, cfg.cone_slope}))
                       : -33'(signed'({1'b0, cfg.cone_slope}));

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= in_valid;
    if (en) begin
      rej_a <= in_rej;
      sa    <= seg_in;
      ksl   <= ks;
      c_a1  <= 64'(seg_in.x1) * 64'(seg_in.y2);
      c_a2  <= 64'(seg_in.x2) * 64'(seg_in.y1);
      d_kx  <= 64'(ks) * (64'(seg_in.x1) - 64'(seg_in.x2));
      o1l   <= 64'(seg_in.x1) * 64'(signed'({1'b0, cfg.cone_slope}));
      o2l   <= 64'(seg_in.x2) * 64'(signed'({1'b0, cfg.cone_slope}));
    end
  end

  // stage b: numerator, denominator and outside flags
  logic               vb, rej_b, out1_b, out2_b;
  seg_t               sb;
  logic signed [32:0] ksb;
  logic signed [NumW-1:0] num_b;
  logic signed [65:0] den_b;
  logic signed [63:0] r1, r2;

  always_comb begin
    r1 = Positive ? 64'(sa.y1) <<< 16 : -(64'(sa.y1) <<< 16);
    r2 = Positive ? 64'(sa.y2) <<< 16 : -(64'(sa.y2) <<< 16);
  end

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
    if (en) begin
      rej_b  <= rej_a;
      sb     <= sa;
      ksb    <= ksl;
      num_b  <= NumW'(-(66'(c_a1) - 66'(c_a2))) <<< 16;
      den_b  <= ((66'(sa.y1) - 66'(sa.y2)) <<< 16) - 66'(d_kx);
      out1_b <= o1l < r1;
      out2_b <= o2l < r2;
    end
  end

  logic zero_den;
  assign zero_den = den_b == '0;

  logic                 vq, negq;
  logic [NumW-1:0]      qmag;
  logic [TagW+2-1:0]    tq;
  logic signed [32:0]   ksq;
  logic                 zq;

  wcp_divider #(.NumWidth(NumW), .DenWidth(66), .TagWidth(TagW + 2)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(vb),
    .num(num_b), .den(zero_den ? 66'sd1 : den_b),
    .tag_in({rej_b, zero_den, out1_b, out2_b, sb}),
    .out_valid(vq), .quot_mag(qmag), .quot_neg(negq), .tag_out(tq)
  );

  wcp_delay #(.Width(34), .Depth(NumW)) u_kdly (
    .clk(clk), .en(en), .d({zero_den, ksb}), .q({zq, ksq})
  );

  // stage c: saturate crossing x and form k*x
  logic               vc, rej_c, z_c, o1c, o2c;
  seg_t               sc, sq;
  logic signed [31:0] ix_c;
  logic signed [63:0] kx_c;
  logic               rq, dzq, o1q, o2q;
  logic [31:0]        qsat;
  logic signed [31:0] ix_n;

  assign {rq, dzq, o1q, o2q, sq} = tq;
  assign qsat = (qmag > NumW'(32'd1073741824)) ? 32'd1073741824 : qmag[31:0];
  assign ix_n = negq ? -signed'(qsat) : signed'(qsat);

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vq;
    if (en) begin
      rej_c <= rq;
      z_c   <= dzq | zq;
      o1c   <= o1q;
      o2c   <= o2q;
      sc    <= sq;
      ix_c  <= ix_n;
      kx_c  <= 64'(ksq) * 64'(ix_n);
    end
  end

  // stage d: apply
  logic signed [31:0] iy;
  logic               clips;
  seg_t               seg_next;
  logic               rej_next;
  assign iy    = sat_coord(96'(kx_c >>> 16));
  assign clips = !z_c && ix_c > 0;

  always_comb begin
    seg_next = sc;
    rej_next = rej_c;
    if (!rej_c && clips) begin
      if (o1c && o2c) rej_next = 1'b1;
      if (o1c) begin
        seg_next.x1 = ix_c;
        seg_next.y1 = iy;
      end
      if (o2c) begin
        seg_next.x2 = ix_c;
        seg_next.y2 = iy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vc;
    if (en) begin
      seg_out <= seg_next;
      out_rej <= rej_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/wcp_project.sv -----
// project both ends to columns and rows through six pipelined dividers
`default_nettype none
module wcp_project
  import wcp_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        en,
  input  wire        in_valid,
  input  wire        in_rej,
  input  seg_t       seg,
  input  wire signed [31:0] floor_level,
  input  wire signed [31:0] ceiling_level,
  input  cfg_t       cfg,
  output logic       out_valid,
  output out_word_t  out_word
);

  localparam int NumW = 64;

  logic               va, vis_a;
  seg_t               sa;
  logic signed [63:0] n [6];
  logic signed [63:0] fy1, fy2, hx1w, hx2w, hx1h, hx2h;
  logic signed [33:0] ec, ef;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= in_valid;
    if (en) begin
      vis_a <= !in_rej && seg.x1 > 0 && seg.x2 > 0;
      sa    <= seg;
      fy1   <= 64'(signed'({1'b0, cfg.focal_length})) * 64'(seg.y1);
      fy2   <= 64'(signed'({1'b0, cfg.focal_length})) * 64'(seg.y2);
      hx1w  <= 64'(HalfWidth) * 64'(seg.x1);
      hx2w  <= 64'(HalfWidth) * 64'(seg.x2);
      hx1h  <= 64'(HalfHeight) * 64'(seg.x1);
      hx2h  <= 64'(HalfHeight) * 64'(seg.x2);
      ec    <= 34'(cfg.eye_height) - 34'(ceiling_level);
      ef    <= 34'(cfg.eye_height) - 34'(floor_level);
    end
  end

  always_comb begin
    n[0] = fy1 + hx1w;
    n[1] = fy2 + hx2w;
    n[2] = 64'(ec) + hx1h;
    n[3] = 64'(ef) + hx1h;
    n[4] = 64'(ec) + hx2h;
    n[5] = 64'(ef) + hx2h;
  end

  logic        vq [6];
  logic        nq [6];
  logic [NumW-1:0] mq [6];
  logic [64:0] tg;
  logic signed [15:0] r [6];

  // left column and both left rows divide by the first depth
  for (genvar i = 0; i < 6; i++) begin : g_div
    logic [64:0] tdummy;
    wcp_divider #(.NumWidth(NumW), .DenWidth(32), .TagWidth(65)) u_div (
      .clk(clk), .rst(rst), .en(en), .in_valid(va), .num(n[i]),
      .den((i == 0 || i == 2 || i == 3) ? sa.x1 : sa.x2),
      .tag_in({vis_a, sa.x1, sa.x2}),
      .out_valid(vq[i]), .quot_mag(mq[i]), .quot_neg(nq[i]), .tag_out(tdummy)
    );
    if (i == 0) begin : g_tag
      assign tg = tdummy;
    end
    assign r[i] = (mq[i][63:15] != '0) ? (nq[i] ? 16'sh8000 : 16'sh7fff)
                : (nq[i] ? -signed'({1'b0, mq[i][14:0]}) : signed'({1'b0, mq[i][14:0]}));
  end

  logic vis_q;
  assign vis_q = tg[64];

  out_word_t out_word_next;

  always_comb begin
    out_word_next = '0;
    out_word_next.visible = vis_q;
    if (vis_q) begin
      out_word_next.left_column  = r[0];
      out_word_next.right_column = r[1];
      out_word_next.facing       = r[0] < r[1];
      out_word_next.top_left     = r[2];
      out_word_next.bottom_left  = r[3];
      out_word_next.top_right    = r[4];
      out_word_next.bottom_right = r[5];
      out_word_next.depth_left   = tg[63:32];
      out_word_next.depth_right  = tg[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vq[0];
    if (en) out_word <= out_word_next;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/wall_clip_project.sv -----
// top level: wall clip and project pipeline with configuration registers
// throughput: one wall per cycle; the whole pipeline stalls while a result word waits
// in_ready follows out_ready in the same cycle, so a waiting result holds the input
// reset: registers take their defaults and every pipeline valid bit clears
`default_nettype none
module wall_clip_project
  import wcp_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  wire         out_ready,
  output out_word_t   out_word,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.viewer_x     <= '0;
      cfg.viewer_y     <= '0;
      cfg.cos_heading  <= 32'sd1073741824;
      cfg.sin_heading  <= '0;
      cfg.eye_height   <= 32'sd1310720;
      cfg.cone_slope   <= 31'd244584;
      cfg.focal_length <= 12'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegViewerX:    cfg.viewer_x     <= cfg_data;
        RegViewerY:    cfg.viewer_y     <= cfg_data;
        RegCosHeading: cfg.cos_heading  <= cfg_data;
        RegSinHeading: cfg.sin_heading  <= cfg_data;
        RegEyeHeight:  cfg.eye_height   <= cfg_data;
        RegConeSlope:  cfg.cone_slope   <= cfg_data[30:0];
        RegFocal:      cfg.focal_length <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // pipeline advances when the output slot is empty or its word is being taken
  logic en;
  logic pipe_valid;
  out_word_t pipe_word;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic   rv, c1v, c1r, c2v, c2r;
  seg_t   rs, c1s, c2s;
  logic [63:0] hts;

  wcp_rotate u_rot (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid && in_ready), .in_word(in_word),
    .cfg(cfg), .out_valid(rv), .seg(rs)
  );

  localparam int ClipLat = 84;
  wcp_delay #(.Width(64), .Depth(3 + 2 * ClipLat)) u_hdly (
    .clk(clk), .en(en), .d({in_word.floor_level, in_word.ceiling_level}), .q(hts)
  );

  wcp_clip #(.Positive(1'b0)) u_clip_lo (
    .clk(clk), .rst(rst), .en(en), .in_valid(rv), .in_rej(1'b0), .seg_in(rs),
    .cfg(cfg), .out_valid(c1v), .out_rej(c1r), .seg_out(c1s)
  );

  wcp_clip #(.Positive(1'b1)) u_clip_hi (
    .clk(clk), .rst(rst), .en(en), .in_valid(c1v), .in_rej(c1r), .seg_in(c1s),
    .cfg(cfg), .out_valid(c2v), .out_rej(c2r), .seg_out(c2s)
  );

  wcp_project u_proj (
    .clk(clk), .rst(rst), .en(en), .in_valid(c2v), .in_rej(c2r), .seg(c2s),
    .floor_level(hts[63:32]), .ceiling_level(hts[31:0]), .cfg(cfg),
    .out_valid(pipe_valid), .out_word(pipe_word)
  );

  assign out_valid = pipe_valid;
  assign out_word  = pipe_word;

  property p_stall_hold;
    @(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid;
  endproperty
  a_stall_hold: assert property (p_stall_hold) else $error("result word dropped on stall");

  property p_vis_depth;
    @(posedge clk) disable iff (rst)
      out_valid && out_word.visible |-> out_word.depth_left > 0 && out_word.depth_right > 0;
  endproperty
  a_vis_depth: assert property (p_vis_depth) else $error("visible wall with bad depth");

  property p_hidden_zero;
    @(posedge clk) disable iff (rst)
      out_valid && !out_word.visible |-> out_word.depth_left == 0 && !out_word.facing;
  endproperty
  a_hidden_zero: assert property (p_hidden_zero) else $error("hidden wall with data");

endmodule
`default_nettype wire

// ----- tb/sv/wall_clip_project_tb.sv -----
// testbench: random and directed walls through the clip and project block, checked against a predictor
`default_nettype none
module wall_clip_project_tb;
  import wcp_pkg::*;

  localparam longint Lim = longint'(1) << 30;
  localparam longint Low30 = (longint'(1) << 30) - 1;

  class wall_scoreboard;
    longint vx, vy, cosh, sinh, eye, slope, focal;
    longint seg[4];
    out_word_t expected_q[$];
    int errors;

    function new();
      errors = 0;
      reset_regs();
    endfunction

    function void reset_regs();
      vx = 0; vy = 0; cosh = 1073741824; sinh = 0;
      eye = 1310720; slope = 244584; focal = 500;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        RegViewerX:    vx = longint'($signed(data));
        RegViewerY:    vy = longint'($signed(data));
        RegCosHeading: cosh = longint'($signed(data));
        RegSinHeading: sinh = longint'($signed(data));
        RegEyeHeight:  eye = longint'($signed(data));
        RegConeSlope:  slope = longint'(data[30:0]);
        RegFocal:      focal = longint'(data[11:0]);
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // exact floor((a + b) / 2^30)
    function longint rot_floor(longint a, longint b);
      longint unsigned lo;
      lo = (longint'(a) & Low30) + (longint'(b) & Low30);
      return (a >>> 30) + (b >>> 30) + longint'(lo >> 30);
    endfunction

    function longint quot_q16(longint num, longint den);
      bit neg;
      longint unsigned un, ud, q, r;
      neg = (num < 0) != (den < 0);
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      q = un / ud;
      r = un % ud;
      if (q >= (64'd1 << 15)) q = Lim;
      else begin
        for (int i = 0; i < 16; i++) begin
          r = r << 1;
          q = q << 1;
          if (r >= ud) begin
            r = r - ud;
            q = q | 1;
          end
        end
        if (q > Lim) q = Lim;
      end
      return neg ? -longint'(q) : longint'(q);
    endfunction

    // clips seg against one cone line; true when both ends lie outside and the crossing x is positive
    function bit clip_line(longint sgn);
      longint k, d, c, ix, iy;
      bit out1, out2;
      k = sgn * slope;
      d = (seg[1] - seg[3]) * 65536 - k * (seg[0] - seg[2]);
      if (d == 0) return 0;
      c = seg[0] * seg[3] - seg[2] * seg[1];
      ix = quot_q16(-c, d);
      if (ix <= 0) return 0;
      iy = clamp((k * ix) >>> 16, -Lim, Lim);
      out1 = seg[0] * slope < sgn * seg[1] * 65536;
      out2 = seg[2] * slope < sgn * seg[3] * 65536;
      if (out1 && out2) return 1;
      if (out1) begin
        seg[0] = ix; seg[1] = iy;
      end
      if (out2) begin
        seg[2] = ix; seg[3] = iy;
      end
      return 0;
    endfunction

    function logic signed [15:0] screen_pos(longint num, longint half, longint x);
      longint v;
      v = clamp((num + half * x) / x, -32768, 32767);
      return v[15:0];
    endfunction

    function out_word_t project_wall(in_word_t w);
      longint dx1, dy1, dx2, dy2, fl, ce;
      bit rej;
      out_word_t r;
      dx1 = longint'(w.start_x) - vx;
      dy1 = longint'(w.start_y) - vy;
      dx2 = longint'(w.end_x) - vx;
      dy2 = longint'(w.end_y) - vy;
      fl = longint'(w.floor_level);
      ce = longint'(w.ceiling_level);
      seg[0] = clamp(rot_floor(dx1 * cosh, dy1 * sinh), -Lim, Lim);
      seg[1] = clamp(rot_floor(dy1 * cosh, -(dx1 * sinh)), -Lim, Lim);
      seg[2] = clamp(rot_floor(dx2 * cosh, dy2 * sinh), -Lim, Lim);
      seg[3] = clamp(rot_floor(dy2 * cosh, -(dx2 * sinh)), -Lim, Lim);
      rej = clip_line(-1);
      if (!rej) rej = clip_line(1);
      r = '0;
      if (!rej && seg[0] > 0 && seg[2] > 0) begin
        r.visible = 1'b1;
        r.left_column = screen_pos(focal * seg[1], HalfWidth, seg[0]);
        r.right_column = screen_pos(focal * seg[3], HalfWidth, seg[2]);
        r.facing = r.left_column < r.right_column;
        r.top_left = screen_pos(eye - ce, HalfHeight, seg[0]);
        r.bottom_left = screen_pos(eye - fl, HalfHeight, seg[0]);
        r.top_right = screen_pos(eye - ce, HalfHeight, seg[2]);
        r.bottom_right = screen_pos(eye - fl, HalfHeight, seg[2]);
        r.depth_left = seg[0][31:0];
        r.depth_right = seg[2][31:0];
      end
      return r;
    endfunction

    function void note_input(in_word_t w);
      expected_q.push_back(project_wall(w));
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(out_word_t a);
      out_word_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("visible", e.visible, a.visible);
      cmp("facing", e.facing, a.facing);
      cmp("left_column", e.left_column, a.left_column);
      cmp("right_column", e.right_column, a.right_column);
      cmp("top_left", e.top_left, a.top_left);
      cmp("bottom_left", e.bottom_left, a.bottom_left);
      cmp("top_right", e.top_right, a.top_right);
      cmp("bottom_right", e.bottom_right, a.bottom_right);
      cmp("depth_left", e.depth_left, a.depth_left);
      cmp("depth_right", e.depth_right, a.depth_right);
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_we;
  in_word_t in_word;
  out_word_t out_word;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  wall_scoreboard sb = new();
  bit calm = 0;
  bit hold_req = 0;
  int gap_pct = 20;

  always #1 clk = ~clk;

  wall_clip_project u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_word);
  end

  // receiver side
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_wall(in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(w);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic reg_done();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(longint c);
    longint v;
    case ($urandom_range(0, 9))
      7, 8: return $urandom;
      9: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          default: return 32'hffffffff;
        endcase
      end
      default: begin
        v = c + (longint'($signed($urandom)) >>> $urandom_range(6, 22));
        return v[31:0];
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_height();
    longint v;
    if ($urandom_range(0, 4) == 0) return $urandom;
    v = sb.eye + (longint'($signed($urandom)) >>> $urandom_range(8, 20));
    return v[31:0];
  endfunction

  task automatic random_walls(int n);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.start_x = rand_coord(sb.vx);
      w.start_y = rand_coord(sb.vy);
      w.end_x = rand_coord(sb.vx);
      w.end_y = rand_coord(sb.vy);
      w.floor_level = rand_height();
      w.ceiling_level = rand_height();
      send_wall(w);
    end
  endtask

  function automatic in_word_t mk(longint sx, longint sy, longint ex, longint ey,
                                  longint fl, longint ce);
    in_word_t w;
    w.start_x = sx[31:0]; w.start_y = sy[31:0];
    w.end_x = ex[31:0]; w.end_y = ey[31:0];
    w.floor_level = fl[31:0]; w.ceiling_level = ce[31:0];
    return w;
  endfunction

  localparam longint U = 65536;
  localparam longint Mx = 2147483647;
  localparam longint Mn = -(longint'(1) << 31);

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walls at the reset settings
    send_wall(mk(100*U, -20*U, 100*U, 20*U, 0, 40*U));
    send_wall(mk(100*U, 20*U, 100*U, -20*U, 0, 40*U));
    send_wall(mk(-100*U, -20*U, -100*U, 20*U, 0, 40*U));
    send_wall(mk(10*U, -200*U, 50*U, 0, 0, 40*U));
    send_wall(mk(50*U, 0, 10*U, 200*U, -5*U, 60*U));
    send_wall(mk(10*U, -500*U, 10*U, 500*U, 0, 40*U));
    send_wall(mk(10*U, 100*U, 10*U, 200*U, 0, 40*U));
    send_wall(mk(10*U, -100*U, 10*U, -200*U, 0, 40*U));
    send_wall(mk(655360, 0, 720896, 244584, 0, 40*U));
    send_wall(mk(5*U, 0, 5*U, 0, 0, 40*U));
    send_wall(mk(0, 0, 0, 0, 0, 0));
    send_wall(mk(1, -1, 1, 1, Mn, Mx));
    send_wall(mk(Mx, Mx, Mx, Mx, Mx, Mx));
    send_wall(mk(Mn, Mn, Mn, Mn, Mn, Mn));
    send_wall(mk(Mx, Mn, Mx, Mx, Mx, Mn));
    send_wall(mk(-50*U, -400*U, 300*U, 100*U, Mn, Mx));
    send_wall(mk(20000*U, -1*U, 20000*U, 1*U, 0, 40*U));
    drain();

    random_walls(100);
    drain();

    // turned viewer, with a long stall of the result side
    reg_write(RegViewerX, 32'(37 * U));
    reg_write(RegViewerY, 32'(-12 * U));
    reg_write(RegCosHeading, 32'd759250125);
    reg_write(RegSinHeading, 32'd759250125);
    reg_write(RegEyeHeight, 32'(7 * U));
    reg_done();
    hold_req = 1;
    random_walls(250);
    drain();

    // extremes
    reg_write(RegViewerX, 32'h7fffffff);
    reg_write(RegViewerY, 32'h80000000);
    reg_write(RegCosHeading, -32'sd1073741824);
    reg_write(RegSinHeading, 32'd0);
    reg_write(RegEyeHeight, 32'h80000000);
    reg_write(RegConeSlope, 32'h7fffffff);
    reg_write(RegFocal, 32'd4095);
    reg_done();
    gap_pct = 0;
    random_walls(200);
    drain();

    // degenerate cone, no horizontal scale, unused index
    reg_write(RegViewerX, 32'd0);
    reg_write(RegViewerY, 32'd0);
    reg_write(RegCosHeading, 32'd0);
    reg_write(RegSinHeading, 32'd1073741824);
    reg_write(RegEyeHeight, 32'h7fffffff);
    reg_write(RegConeSlope, 32'd0);
    reg_write(RegFocal, 32'd0);
    reg_write(3'd7, $urandom);
    reg_done();
    gap_pct = 40;
    send_wall(mk(-20*U, 100*U, 20*U, 100*U, 0, 40*U));
    send_wall(mk(-20*U, 100*U, 0, 100*U, 0, 40*U));
    random_walls(200);
    drain();

    // random settings
    for (int ph = 0; ph < 3; ph++) begin
      reg_write(RegViewerX, $urandom);
      reg_write(RegViewerY, $urandom);
      reg_write(RegCosHeading, 32'($signed($urandom_range(0, 32'h80000000)) - 1073741824));
      reg_write(RegSinHeading, 32'($signed($urandom_range(0, 32'h80000000)) - 1073741824));
      reg_write(RegEyeHeight, $urandom);
      reg_write(RegConeSlope, $urandom_range(1, 1 << 20));
      reg_write(RegFocal, $urandom_range(1, 4095));
      reg_done();
      gap_pct = $urandom_range(0, 40);
      random_walls(180);
      drain();
    end

    // narrowest cone and scale
    reg_write(RegCosHeading, -32'sd1073741824);
    reg_write(RegSinHeading, -32'sd1073741824);
    reg_write(RegConeSlope, 32'd1);
    reg_write(RegFocal, 32'd1);
    reg_done();
    gap_pct = 20;
    random_walls(150);
    drain();

    // reset settings again, no idling at the end
    reg_write(RegViewerX, 32'd0);
    reg_write(RegViewerY, 32'd0);
    reg_write(RegCosHeading, 32'd1073741824);
    reg_write(RegSinHeading, 32'd0);
    reg_write(RegEyeHeight, 32'd1310720);
    reg_write(RegConeSlope, 32'd244584);
    reg_write(RegFocal, 32'd500);
    reg_done();
    random_walls(150);
    calm = 1;
    random_walls(200);
    drain();

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
